// ===== rtl/lobm_pkg.sv =====
// Package: shared constants and types for the limit order book matcher.
`default_nettype none
package lobm_pkg;
  localparam int MaxOrders = 256;
  localparam int SlotW     = $clog2(MaxOrders);
  localparam int CntW      = $clog2(MaxOrders + 1);
  localparam int RecW      = 128;

  localparam logic [2:0] StAccepted  = 3'd0;
  localparam logic [2:0] StFilled    = 3'd1;
  localparam logic [2:0] StPartial   = 3'd2;
  localparam logic [2:0] StRejected  = 3'd3;
  localparam logic [2:0] StCancelled = 3'd4;
  localparam logic [2:0] StNotFound  = 3'd5;
  localparam logic [2:0] StFull      = 3'd6;

  localparam logic ModeAdd    = 1'b0;
  localparam logic ModeCancel = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [31:0] arrival;
  } slot_rec_t;
endpackage
`default_nettype wire

// ===== rtl/limit_order_book_matcher_core.sv =====
// Top level: price-time priority order book with a sequential slot scanner.
//
// Each transaction is handled by walking the slot table one slot per cycle
// through a single RAM port and one shared compare unit. One scan covers
// MaxOrders slots; the RAM read is registered, and each scan ends with a
// drain step. A cancel or a rejected add takes two scans: the id
// lookup, then a final scan that refreshes best bid and ask. An accepted
// add takes the id lookup, one match scan per fill, one more match scan when
// the order is not completely filled (the scan that finds nothing crossing),
// then the final scan, which also locates a free slot. Each fill adds one
// update state and storing a remainder adds one store state. On top of
// that come the idle state in which the transaction is accepted and the
// output state that presents the result. The cost of a transaction is
// thus set by its number of scans through the single RAM port.
// in_ready is high only while idle, and the result register frees as soon
// as it is taken.
`default_nettype none
module limit_order_book_matcher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_order_key,
  input  wire logic        in_is_ask,
  input  wire logic [31:0] in_limit_price,
  input  wire logic [31:0] in_order_qty,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_filled_qty,
  output logic [31:0]      out_best_bid_price,
  output logic             out_best_bid_valid,
  output logic [31:0]      out_best_ask_price,
  output logic             out_best_ask_valid,
  output logic [8:0]       out_resting_total
);
  import lobm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DUP, S_MATCH, S_FILL, S_FINAL, S_STORE, S_OUT
  } state_t;

  state_t state_r;

  // Scan bookkeeping: address issued, then data back in the next cycle.
  logic [SlotW:0]   idx_r;
  logic             rd_v_r;
  logic [SlotW-1:0] rd_idx_r;

  logic             mode_r, ask_r;
  logic [31:0]      key_r, price_r, left_r, filled_r, arrival_r;
  logic [CntW-1:0]  occ_r;
  logic [MaxOrders-1:0] valid_r, side_r;

  // Search results.
  logic             hit_r;
  logic [SlotW-1:0] hit_idx_r;
  logic             free_v_r;
  logic [SlotW-1:0] free_idx_r;
  logic             bb_v_r, ba_v_r;
  logic [31:0]      bb_p_r, bb_a_r, ba_p_r, ba_a_r;
  slot_rec_t        best_rec_r;
  logic [2:0]       status_r;

  logic             we;
  logic [SlotW-1:0] addr;
  slot_rec_t        wdata, rdata;

  lobm_ram #(.Width(RecW), .Depth(MaxOrders)) u_slots (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic scan_done;
  logic rd_live, rd_ask;
  logic better_bid, better_ask;
  logic [31:0] fill_q;

  assign scan_done = idx_r[SlotW] && !rd_v_r;
  assign rd_live   = rd_v_r && valid_r[rd_idx_r];
  assign rd_ask    = side_r[rd_idx_r];
  assign better_bid = !bb_v_r || (rdata.price > bb_p_r) ||
                      (rdata.price == bb_p_r && rdata.arrival < bb_a_r);
  assign better_ask = !ba_v_r || (rdata.price < ba_p_r) ||
                      (rdata.price == ba_p_r && rdata.arrival < ba_a_r);
  assign fill_q = (left_r < best_rec_r.remaining) ? left_r : best_rec_r.remaining;

  always_comb begin
    we    = 1'b0;
    addr  = idx_r[SlotW-1:0];
    wdata = best_rec_r;
    if (state_r == S_FILL) begin
      we    = 1'b1;
      addr  = hit_idx_r;
      wdata.remaining = best_rec_r.remaining - fill_q;
    end else if (state_r == S_STORE) begin
      we    = 1'b1;
      addr  = free_idx_r;
      wdata = '{id: key_r, price: price_r, remaining: left_r, arrival: arrival_r};
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign out_filled_qty = filled_r;
  assign out_best_bid_price = bb_v_r ? bb_p_r : 32'd0;
  assign out_best_bid_valid = bb_v_r;
  assign out_best_ask_price = ba_v_r ? ba_p_r : 32'd0;
  assign out_best_ask_valid = ba_v_r;
  assign out_resting_total = 9'(occ_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      occ_r     <= '0;
      arrival_r <= '0;
      rd_v_r    <= 1'b0;
      idx_r     <= '0;
      bb_v_r    <= 1'b0;
      ba_v_r    <= 1'b0;
    end else begin
      // Scanner advances in every scan state.
      if (state_r == S_DUP || state_r == S_MATCH || state_r == S_FINAL) begin
        rd_v_r   <= !idx_r[SlotW];
        rd_idx_r <= idx_r[SlotW-1:0];
        if (!idx_r[SlotW]) idx_r <= idx_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= in_mode;
            key_r    <= in_order_key;
            ask_r    <= in_is_ask;
            price_r  <= in_limit_price;
            left_r   <= in_order_qty;
            filled_r <= '0;
            hit_r    <= 1'b0;
            idx_r    <= '0;
            rd_v_r   <= 1'b0;
            state_r  <= S_DUP;
          end
        end
        S_DUP: begin
          if (rd_live && rdata.id == key_r && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= rd_idx_r;
          end
          if (scan_done) begin
            idx_r <= '0;
            if (mode_r == ModeCancel) begin
              if (hit_r && key_r != 32'd0) begin
                valid_r[hit_idx_r] <= 1'b0;
                occ_r    <= occ_r - 1'b1;
                status_r <= StCancelled;
              end else begin
                status_r <= StNotFound;
              end
              state_r <= S_FINAL;
            end else if (hit_r || key_r == 32'd0 || left_r == 32'd0) begin
              status_r <= StRejected;
              state_r  <= S_FINAL;
            end else begin
              hit_r   <= 1'b0;
              state_r <= S_MATCH;
            end
            bb_v_r <= 1'b0; ba_v_r <= 1'b0; free_v_r <= 1'b0;
          end
        end
        S_MATCH: begin
          // Find best opposite order; reuse hit_r as "any found".
          if (rd_live && rd_ask != ask_r) begin
            if (ask_r ? better_bid : better_ask) begin
              hit_r <= 1'b1;
              hit_idx_r <= rd_idx_r;
              best_rec_r <= rdata;
              if (ask_r) begin
                bb_v_r <= 1'b1; bb_p_r <= rdata.price; bb_a_r <= rdata.arrival;
              end else begin
                ba_v_r <= 1'b1; ba_p_r <= rdata.price; ba_a_r <= rdata.arrival;
              end
            end
          end
          if (scan_done) begin
            idx_r <= '0;
            bb_v_r <= 1'b0; ba_v_r <= 1'b0;
            if (hit_r && (ask_r ? (best_rec_r.price >= price_r)
                                : (best_rec_r.price <= price_r))) begin
              state_r <= S_FILL;
            end else begin
              state_r <= S_FINAL;
            end
          end
        end
        S_FILL: begin
          left_r   <= left_r - fill_q;
          filled_r <= filled_r + fill_q;
          if (fill_q == best_rec_r.remaining) begin
            valid_r[hit_idx_r] <= 1'b0;
            occ_r <= occ_r - 1'b1;
          end
          hit_r <= 1'b0;
          idx_r <= '0;
          state_r <= (fill_q == left_r) ? S_FINAL : S_MATCH;
        end
        S_FINAL: begin
          if (rd_v_r && !valid_r[rd_idx_r] && !free_v_r) begin
            free_v_r <= 1'b1; free_idx_r <= rd_idx_r;
          end
          if (rd_live && !rd_ask && better_bid) begin
            bb_v_r <= 1'b1; bb_p_r <= rdata.price; bb_a_r <= rdata.arrival;
          end
          if (rd_live && rd_ask && better_ask) begin
            ba_v_r <= 1'b1; ba_p_r <= rdata.price; ba_a_r <= rdata.arrival;
          end
          if (scan_done) begin
            if (mode_r == ModeCancel || status_r == StRejected) begin
              state_r <= S_OUT;
            end else if (left_r == 32'd0) begin
              status_r <= StFilled;
              state_r  <= S_OUT;
            end else if (!free_v_r) begin
              status_r <= StFull;
              state_r  <= S_OUT;
            end else begin
              status_r <= (filled_r != 32'd0) ? StPartial : StAccepted;
              state_r  <= S_STORE;
            end
          end
        end
        S_STORE: begin
          valid_r[free_idx_r] <= 1'b1;
          side_r[free_idx_r]  <= ask_r;
          occ_r     <= occ_r + 1'b1;
          arrival_r <= arrival_r + 1'b1;
          if (!ask_r && (!bb_v_r || price_r > bb_p_r)) begin
            bb_v_r <= 1'b1; bb_p_r <= price_r; bb_a_r <= arrival_r;
          end
          if (ask_r && (!ba_v_r || price_r < ba_p_r)) begin
            ba_v_r <= 1'b1; ba_p_r <= price_r; ba_a_r <= arrival_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // Clear match status marker at entry.
      if (state_r == S_IDLE && in_valid) status_r <= StAccepted;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(MaxOrders))
    else $error("occupancy overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> valid_r[hit_idx_r])
    else $error("fill on invalid slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |-> !valid_r[free_idx_r])
    else $error("store over live slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("ready while result pending");
endmodule
`default_nettype wire

// ===== rtl/lobm_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module lobm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sim/lobm_checker.sv =====
// Checker: watches both channels, predicts book results, compares them.
module lobm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_order_key,
  input  wire logic        in_is_ask,
  input  wire logic [31:0] in_limit_price,
  input  wire logic [31:0] in_order_qty,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_status,
  input  wire logic [31:0] out_filled_qty,
  input  wire logic [31:0] out_best_bid_price,
  input  wire logic        out_best_bid_valid,
  input  wire logic [31:0] out_best_ask_price,
  input  wire logic        out_best_ask_valid,
  input  wire logic [8:0]  out_resting_total,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] filled;
    logic [31:0] bid_px;
    logic        bid_ok;
    logic [31:0] ask_px;
    logic        ask_ok;
    logic [8:0]  total;
  } book_result_t;

  localparam int NoSlot = -1;

  logic [31:0] bk_id [MaxOrders];
  logic [31:0] bk_px [MaxOrders];
  logic [31:0] bk_rem [MaxOrders];
  logic [31:0] bk_age [MaxOrders];
  logic        bk_live [MaxOrders];
  logic        bk_ask [MaxOrders];
  logic [31:0] age_next;
  logic [8:0]  live_cnt;
  book_result_t expected_results[$];

  function automatic int lookup_id(logic [31:0] key);
    for (int i = 0; i < MaxOrders; i++)
      if (bk_live[i] && bk_id[i] == key) return i;
    return NoSlot;
  endfunction

  function automatic int top_of_side(logic ask_side);
    int b;
    b = NoSlot;
    for (int i = 0; i < MaxOrders; i++) begin
      if (!bk_live[i] || bk_ask[i] != ask_side) continue;
      if (b == NoSlot) b = i;
      else if (bk_px[i] != bk_px[b]) begin
        if (ask_side ? bk_px[i] < bk_px[b] : bk_px[i] > bk_px[b]) b = i;
      end else if (bk_age[i] < bk_age[b]) b = i;
    end
    return b;
  endfunction

  function automatic book_result_t match_order(logic md, logic [31:0] key, logic ask,
                                               logic [31:0] px, logic [31:0] qty);
    book_result_t r;
    logic [31:0] left, f;
    int s, p;
    r = '0;
    if (md == ModeCancel) begin
      s = (key == 0) ? NoSlot : lookup_id(key);
      if (s == NoSlot) r.status = StNotFound;
      else begin
        bk_live[s] = 1'b0;
        live_cnt--;
        r.status = StCancelled;
      end
    end else if (qty == 0 || key == 0 || lookup_id(key) != NoSlot) begin
      r.status = StRejected;
    end else begin
      left = qty;
      while (left > 0) begin
        p = top_of_side(!ask);
        if (p == NoSlot) break;
        if (ask ? bk_px[p] < px : bk_px[p] > px) break;
        f = left < bk_rem[p] ? left : bk_rem[p];
        left -= f;
        r.filled += f;
        bk_rem[p] -= f;
        if (bk_rem[p] == 0) begin
          bk_live[p] = 1'b0;
          live_cnt--;
        end
      end
      if (left == 0) r.status = StFilled;
      else begin
        s = NoSlot;
        for (int i = 0; i < MaxOrders; i++)
          if (!bk_live[i]) begin
            s = i;
            break;
          end
        if (s == NoSlot) r.status = StFull;
        else begin
          bk_id[s] = key;
          bk_px[s] = px;
          bk_rem[s] = left;
          bk_age[s] = age_next;
          bk_live[s] = 1'b1;
          bk_ask[s] = ask;
          age_next++;
          live_cnt++;
          r.status = r.filled > 0 ? StPartial : StAccepted;
        end
      end
    end
    p = top_of_side(1'b0);
    if (p != NoSlot) begin
      r.bid_px = bk_px[p];
      r.bid_ok = 1'b1;
    end
    p = top_of_side(1'b1);
    if (p != NoSlot) begin
      r.ask_px = bk_px[p];
      r.ask_ok = 1'b1;
    end
    r.total = live_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    book_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < MaxOrders; i++) bk_live[i] = 1'b0;
      age_next = 0;
      live_cnt = 0;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(match_order(in_mode, in_order_key, in_is_ask,
                                               in_limit_price, in_order_qty));
      if (out_valid && out_ready) begin
        got = '{out_status, out_filled_qty, out_best_bid_price, out_best_bid_valid,
                out_best_ask_price, out_best_ask_valid, out_resting_total};
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got != want) begin
            $display("%0t: result mismatch expected st=%0d fill=%0d bid=%0d/%0d ask=%0d/%0d n=%0d",
                     $time, want.status, want.filled, want.bid_ok, want.bid_px,
                     want.ask_ok, want.ask_px, want.total);
            $display("%0t:                  actual st=%0d fill=%0d bid=%0d/%0d ask=%0d/%0d n=%0d",
                     $time, got.status, got.filled, got.bid_ok, got.bid_px,
                     got.ask_ok, got.ask_px, got.total);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top: drives order transactions into the book and reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = ModeAdd;
  logic [31:0] in_order_key = '0;
  logic        in_is_ask = 1'b0;
  logic [31:0] in_limit_price = '0;
  logic [31:0] in_order_qty = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_filled_qty, out_best_bid_price, out_best_ask_price;
  logic        out_best_bid_valid, out_best_ask_valid;
  logic [8:0]  out_resting_total;
  int          fail_count, pending_count, result_count;
  bit          calm_tail = 1'b0;
  bit          hold_sink = 1'b0;
  int          adds_sent = 0, cancels_sent = 0;
  logic [31:0] key_pool[$];
  logic [31:0] next_key = 32'd100;

  always #5 clk = ~clk;

  limit_order_book_matcher_core u_dut (.*);

  lobm_checker u_chk (.*);

  // Accept results with random stall bursts; hold off when asked.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_order(logic md, logic [31:0] key, logic ask, logic [31:0] px,
                            logic [31:0] qty);
    int gap;
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_order_key <= key;
    in_is_ask <= ask;
    in_limit_price <= px;
    in_order_qty <= qty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (md == ModeAdd) adds_sent++;
    else cancels_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk);
  endtask

  // Random order or cancel, with prices near a mid unless wide is set, so books cross often.
  task automatic random_order(int wide);
    logic [31:0] key, px, qty;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 4 && key_pool.size() > 0) begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_order(ModeCancel, key, 1'($urandom_range(0, 1)), $urandom, $urandom);
    end else if (pick == 4) begin
      send_order(ModeCancel, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
    end else if (pick == 5 && key_pool.size() > 0) begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_order(ModeAdd, key, 1'($urandom_range(0, 1)), $urandom, $urandom_range(1, 50));
    end else if (pick == 6) begin
      send_order(ModeAdd, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
    end else begin
      key = next_key;
      next_key++;
      key_pool.push_back(key);
      if (key_pool.size() > 64) key_pool.delete(0);
      px = wide ? $urandom : 32'd1000 + $urandom_range(0, 20) - 10;
      qty = $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(1, 40);
      send_order(ModeAdd, key, 1'($urandom_range(0, 1)), px, qty);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects, unknown cancels, extremes, a sweep and a partial fill.
    send_order(ModeAdd, 32'd0, 1'b0, 32'd10, 32'd5);
    send_order(ModeAdd, 32'd1, 1'b0, 32'd10, 32'd0);
    send_order(ModeCancel, 32'd0, 1'b0, 32'd0, 32'd0);
    send_order(ModeCancel, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(ModeAdd, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(ModeAdd, 32'd2, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_order(ModeAdd, 32'd2, 1'b1, 32'd5, 32'd3);
    send_order(ModeAdd, 32'd3, 1'b1, 32'd20, 32'd4);
    send_order(ModeAdd, 32'd4, 1'b1, 32'd20, 32'd6);
    send_order(ModeAdd, 32'd5, 1'b1, 32'd15, 32'd2);
    send_order(ModeAdd, 32'd6, 1'b0, 32'd20, 32'd5);
    send_order(ModeAdd, 32'd7, 1'b0, 32'd25, 32'd20);
    send_order(ModeAdd, 32'd8, 1'b1, 32'd0, 32'd1);
    send_order(ModeCancel, 32'd7, 1'b0, 32'd0, 32'd0);
    send_order(ModeCancel, 32'd7, 1'b0, 32'd0, 32'd0);
    send_order(ModeCancel, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
    send_order(ModeCancel, 32'd2, 1'b0, 32'd0, 32'd0);
    send_order(ModeAdd, 32'h8000_0000, 1'b0, 32'hAAAA_5555, 32'h5555_AAAA);
    send_order(ModeAdd, 32'h7FFF_FFFF, 1'b1, 32'h5555_AAAA, 32'hAAAA_5555);
    send_order(ModeCancel, 32'h8000_0000, 1'b0, 32'd0, 32'd0);
    drop_valid();
    wait_drained();

    // Fill the table with non-crossing orders, then overflow it.
    for (int i = 0; i < MaxOrders; i++)
      send_order(ModeAdd, 32'h1000 + i, i[0], i[0] ? 32'd5000 + i : 32'd100 + i,
                 32'd1 + i);
    send_order(ModeAdd, 32'h2000, 1'b0, 32'd50, 32'd3);
    send_order(ModeAdd, 32'h2001, 1'b0, 32'd5001, 32'd1000);
    send_order(ModeAdd, 32'h2002, 1'b1, 32'd100, 32'd2);
    for (int i = 0; i < MaxOrders; i++)
      send_order(ModeCancel, 32'h1000 + i, 1'b0, 32'd0, 32'd0);
    drop_valid();
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    hold_sink = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
      end
      repeat (40) random_order(0);
    join
    drop_valid();
    wait_drained();

    repeat (700) random_order($urandom_range(0, 9) == 0);
    calm_tail = 1'b1;
    repeat (60) random_order(0);
    drop_valid();

    wait_drained();
    repeat (1000) @(posedge clk);
    $display("Sent %0d adds and %0d cancels; %0d results checked,", adds_sent,
             cancels_sent, result_count);
    $display("including a full table, crossing sweeps and long output stalls.");
    if (fail_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5s;
    $display("Mismatches found");
    $finish;
  end
endmodule
